### design/ulsan_pkg.sv
// ulsan_pkg: shared types, byte constants and decode functions for the utf-8 sanitizer
// used by ulsan_front, ulsan_queue, ulsan_back and utf8_lossy_sanitizer
// no dependencies
package ulsan_pkg;

    // default depth of the job queue between front and back
    localparam int ULSAN_QUEUE_DEPTH = 2;

    // byte classes and limits
    localparam logic [7:0] ULSAN_CONT_MASK  = 8'hC0;
    localparam logic [7:0] ULSAN_CONT_TAG   = 8'h80;
    localparam logic [7:0] ULSAN_LEAD2_LO   = 8'hC2;
    localparam logic [7:0] ULSAN_LEAD2_HI   = 8'hDF;
    localparam logic [7:0] ULSAN_LEAD3_LO   = 8'hE0;
    localparam logic [7:0] ULSAN_LEAD3_HI   = 8'hEF;
    localparam logic [7:0] ULSAN_LEAD4_LO   = 8'hF0;
    localparam logic [7:0] ULSAN_LEAD4_HI   = 8'hF4;
    localparam logic [7:0] ULSAN_LEAD_E0    = 8'hE0;
    localparam logic [7:0] ULSAN_LEAD_ED    = 8'hED;
    localparam logic [7:0] ULSAN_LEAD_F0    = 8'hF0;
    localparam logic [7:0] ULSAN_LEAD_F4    = 8'hF4;
    localparam logic [7:0] ULSAN_LIMIT_A0   = 8'hA0;
    localparam logic [7:0] ULSAN_LIMIT_90   = 8'h90;
    localparam logic [7:0] ULSAN_ASCII_TOP  = 8'h80;

    // U+FFFD as utf-8
    localparam logic [7:0] ULSAN_REPL_B0 = 8'hEF;
    localparam logic [7:0] ULSAN_REPL_B1 = 8'hBF;
    localparam logic [7:0] ULSAN_REPL_B2 = 8'hBD;

    // input transfer payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } ulsan_in_t;

    // result transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_replacement;
        logic       run_end;
        logic       string_end;
    } ulsan_out_t;

    // one job: rep_count replacements, then lit_count literal bytes
    typedef struct packed {
        logic [2:0]      rep_count;
        logic [2:0]      lit_count;
        logic [3:0][7:0] lit;
        logic            last;
    } ulsan_job_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & ULSAN_CONT_MASK) == ULSAN_CONT_TAG;
    endfunction

    // continuation bytes a lead needs, zero when not a valid lead
    function automatic logic [1:0] cont_needed(input logic [7:0] lead);
        logic [1:0] n;
        n = 2'd0;
        if (lead >= ULSAN_LEAD2_LO && lead <= ULSAN_LEAD2_HI) n = 2'd1;
        if (lead >= ULSAN_LEAD3_LO && lead <= ULSAN_LEAD3_HI) n = 2'd2;
        if (lead >= ULSAN_LEAD4_LO && lead <= ULSAN_LEAD4_HI) n = 2'd3;
        return n;
    endfunction

    // second-byte range limits for the overlong and surrogate leads
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        ok = 1'b1;
        if (lead == ULSAN_LEAD_E0 && b <  ULSAN_LIMIT_A0) ok = 1'b0;
        if (lead == ULSAN_LEAD_ED && b >= ULSAN_LIMIT_A0) ok = 1'b0;
        if (lead == ULSAN_LEAD_F0 && b <  ULSAN_LIMIT_90) ok = 1'b0;
        if (lead == ULSAN_LEAD_F4 && b >= ULSAN_LIMIT_90) ok = 1'b0;
        return ok;
    endfunction

    // byte of the replacement sequence at a given phase
    function automatic logic [7:0] repl_byte(input logic [1:0] phase);
        logic [7:0] v;
        case (phase)
            2'd0:    v = ULSAN_REPL_B0;
            2'd1:    v = ULSAN_REPL_B1;
            default: v = ULSAN_REPL_B2;
        endcase
        return v;
    endfunction

endpackage

### design/ulsan_front.sv
// ulsan_front: decodes each accepted byte against the held sequence and emits at most one job
// depends on ulsan_pkg
module ulsan_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  ulsan_pkg::ulsan_in_t  in_data,
    output logic                  push,
    output ulsan_pkg::ulsan_job_t job
);
    import ulsan_pkg::*;

    logic [7:0] held_lead_reg, held_lead_next;
    logic       lead_pending_reg, lead_pending_next;
    logic [1:0] cont_count_reg, cont_count_next;
    logic [1:0][7:0] cont_bytes_reg;

    logic       cont_write;
    logic [7:0] b;
    logic       last;
    logic [1:0] need;
    logic       ok;
    logic       do_fresh;
    logic [2:0] rep_n;
    logic [2:0] lit_n;
    logic [3:0][7:0] lit;

    assign b    = in_data.in_byte;
    assign last = in_data.string_last;

    // decode and next held state
    always_comb begin
        held_lead_next    = held_lead_reg;
        lead_pending_next = lead_pending_reg;
        cont_count_next   = cont_count_reg;
        cont_write        = 1'b0;
        do_fresh          = 1'b0;
        rep_n             = 3'd0;
        lit_n             = 3'd0;
        lit               = '{default: b};
        need              = cont_needed(held_lead_reg);
        ok = is_cont(b) && (cont_count_reg != 2'd0 || second_ok(held_lead_reg, b));

        if (lead_pending_reg) begin
            if (ok && (({1'b0, cont_count_reg} + 3'd1) >= {1'b0, need})) begin
                // sequence complete: send lead, held bytes and this byte
                lit[0] = held_lead_reg;
                lit[1] = (cont_count_reg >= 2'd1) ? cont_bytes_reg[0] : b;
                lit[2] = (cont_count_reg >= 2'd2) ? cont_bytes_reg[1] : b;
                lit[3] = b;
                lit_n  = {1'b0, cont_count_reg} + 3'd2;
                lead_pending_next = 1'b0;
                held_lead_next    = '0;
                cont_count_next   = '0;
            end else if (ok) begin
                // hold one more continuation
                cont_write      = 1'b1;
                cont_count_next = cont_count_reg + 2'd1;
            end else begin
                // broken sequence: flush held bytes, then retry this byte
                rep_n = {1'b0, cont_count_reg} + 3'd1;
                lead_pending_next = 1'b0;
                held_lead_next    = '0;
                cont_count_next   = '0;
                do_fresh          = 1'b1;
            end
        end else begin
            do_fresh = 1'b1;
        end

        // byte seen with nothing held
        if (do_fresh) begin
            if (b < ULSAN_ASCII_TOP) begin
                lit[0] = b;
                lit_n  = 3'd1;
            end else if (cont_needed(b) != 2'd0) begin
                held_lead_next    = b;
                lead_pending_next = 1'b1;
                cont_count_next   = '0;
            end else begin
                rep_n = rep_n + 3'd1;
            end
        end

        // end of string flushes anything still held
        if (last && lead_pending_next) begin
            rep_n = rep_n + 3'd1 + {1'b0, cont_count_next};
            lead_pending_next = 1'b0;
            held_lead_next    = '0;
            cont_count_next   = '0;
        end
    end

    assign push          = accept && (rep_n != 3'd0 || lit_n != 3'd0);
    assign job.rep_count = rep_n;
    assign job.lit_count = lit_n;
    assign job.lit       = lit;
    assign job.last      = last;

    // held sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_lead_reg    <= '0;
            lead_pending_reg <= 1'b0;
            cont_count_reg   <= '0;
        end else if (accept) begin
            held_lead_reg    <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
            cont_count_reg   <= cont_count_next;
        end
    end

    // held continuation bytes
    always_ff @(posedge aclk) begin
        if (accept && cont_write) begin
            cont_bytes_reg[cont_count_reg[0]] <= b;
        end
    end

endmodule

### design/ulsan_queue.sv
// ulsan_queue: small job fifo that decouples the decode front from the output back
// depends on ulsan_pkg
module ulsan_queue #(
    parameter int DEPTH = ulsan_pkg::ULSAN_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ulsan_pkg::ulsan_job_t push_job,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output ulsan_pkg::ulsan_job_t head_job
);
    import ulsan_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ulsan_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### design/ulsan_back.sv
// ulsan_back: expands the head job into an output register, a byte per cycle unless stalled
// depends on ulsan_pkg
module ulsan_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    input  ulsan_pkg::ulsan_job_t  job,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ulsan_pkg::ulsan_out_t  m_data
);
    import ulsan_pkg::*;

    logic [2:0] rep_done_reg, rep_done_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] lit_idx_reg, lit_idx_next;
    logic       m_valid_reg, m_valid_next;
    ulsan_out_t m_data_reg, m_data_next;

    logic       advance;
    logic       in_rep;
    logic       job_done;
    logic [7:0] cur_byte;

    assign advance = !m_valid_reg || m_ready;
    assign in_rep  = rep_done_reg < job.rep_count;

    // pick the current byte of the job and spot its final byte
    always_comb begin
        if (in_rep) begin
            cur_byte = repl_byte(phase_reg);
            job_done = (phase_reg == 2'd2) && (rep_done_reg == job.rep_count - 3'd1)
                       && (job.lit_count == 3'd0);
        end else begin
            cur_byte = job.lit[lit_idx_reg];
            job_done = ({1'b0, lit_idx_reg} == job.lit_count - 3'd1);
        end
    end

    // step through the job as the output register frees up
    always_comb begin
        rep_done_next = rep_done_reg;
        phase_next    = phase_reg;
        lit_idx_next  = lit_idx_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        pop           = 1'b0;
        if (advance) begin
            m_valid_next = job_valid;
            if (job_valid) begin
                m_data_next.out_byte       = cur_byte;
                m_data_next.is_replacement = in_rep;
                m_data_next.run_end        = job_done;
                m_data_next.string_end     = job_done && job.last;
                if (job_done) begin
                    pop           = 1'b1;
                    rep_done_next = '0;
                    phase_next    = '0;
                    lit_idx_next  = '0;
                end else if (in_rep) begin
                    if (phase_reg == 2'd2) begin
                        phase_next    = '0;
                        rep_done_next = rep_done_reg + 3'd1;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end else begin
                    lit_idx_next = lit_idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_done_reg <= '0;
            phase_reg    <= '0;
            lit_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            rep_done_reg <= rep_done_next;
            phase_reg    <= phase_next;
            lit_idx_reg  <= lit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/utf8_lossy_sanitizer.sv
// utf8_lossy_sanitizer: top level of the streaming utf-8 cleaner
// depends on ulsan_pkg, ulsan_front, ulsan_queue, ulsan_back
//
// Takes one raw byte per transfer and emits sanitized utf-8, one byte per transfer.
// Well-formed sequences pass through unchanged; every bad lead, lone continuation
// and every byte of a broken or truncated sequence becomes EF BF BD. A multi-byte
// sequence is held until complete, so its bytes come out after its last byte
// arrives. The front decodes an input byte combinationally and posts at most one job
// to a queue of QUEUE_DEPTH entries; the back writes one output byte per cycle into a
// registered output while m_ready allows. The front takes at most one byte per cycle,
// and the back sends the bytes that an input byte yields (none to 12; one on clean
// ASCII) one at a time, so clean text runs at one byte per cycle while m_ready stays
// high. The job of a byte enters the queue when the byte is taken; the back then loads
// its first result into the output register, where m_valid rises.
module utf8_lossy_sanitizer #(
    parameter int QUEUE_DEPTH = ulsan_pkg::ULSAN_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ulsan_pkg::ulsan_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ulsan_pkg::ulsan_out_t m_data
);
    import ulsan_pkg::*;

    logic       accept;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;
    ulsan_job_t front_job;
    ulsan_job_t head_job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // decode front
    ulsan_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_data),
        .push    (push),
        .job     (front_job)
    );

    // job queue
    ulsan_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (front_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    // output back
    ulsan_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_not_empty),
        .job       (head_job),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
